### design/ecef_enu_pkg.sv
`default_nettype none
package ecef_enu_pkg;

  // CORDIC iteration count for the sin/cos refresh
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  // field widths
  localparam int ANG_W  = 32;
  localparam int IN_W   = 36;
  localparam int OUT_W  = 38;
  localparam int COEF_W = 32;
  localparam int FRAC   = 30;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam logic [CFG_IDX_W-1:0] REG_LATITUDE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONGITUDE = 2'd1;

  // CORDIC datapath
  localparam int CORDIC_W = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_ONE  = 34'sh0_4000_0000;
  localparam logic signed [CORDIC_W-1:0] CORDIC_PI   = 34'sh0_8000_0000;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [COEF_W-1:0]   ONE_Q30     = 32'sh4000_0000;

  // dot-product pipeline: components split into a signed high part and an
  // unsigned low part so each multiplier stays near 18x32
  localparam int SPLIT = 18;
  localparam int HP_W  = IN_W - SPLIT + COEF_W;
  localparam int LP_W  = SPLIT + 1 + COEF_W;
  localparam int HS_W  = HP_W + 2;
  localparam int LS_W  = LP_W + 2;
  localparam int ACC_W = HS_W + SPLIT;

  // rows: east, north, up; columns: x, y, z
  typedef struct packed {
    logic [2:0][2:0][COEF_W-1:0] m;
  } coef_t;

  typedef struct packed {
    logic                     done;
    logic signed [COEF_W-1:0] sin;
    logic signed [COEF_W-1:0] cos;
  } trig_res_t;

  // atan(2^-i) in binary-angle units, 2^31 = pi
  function automatic logic signed [31:0] atan_entry(input logic [5:0] idx);
    logic signed [31:0] v;
    case (idx)
      6'd0:  v = 32'h20000000;
      6'd1:  v = 32'h12E4051E;
      6'd2:  v = 32'h09FB385B;
      6'd3:  v = 32'h051111D4;
      6'd4:  v = 32'h028B0D43;
      6'd5:  v = 32'h0145D7E1;
      6'd6:  v = 32'h00A2F61E;
      6'd7:  v = 32'h00517C55;
      6'd8:  v = 32'h0028BE53;
      6'd9:  v = 32'h00145F2F;
      6'd10: v = 32'h000A2F98;
      6'd11: v = 32'h000517CC;
      6'd12: v = 32'h00028BE6;
      6'd13: v = 32'h000145F3;
      6'd14: v = 32'h0000A2F9;
      6'd15: v = 32'h0000517D;
      6'd16: v = 32'h000028BE;
      6'd17: v = 32'h0000145F;
      6'd18: v = 32'h00000A30;
      6'd19: v = 32'h00000518;
      6'd20: v = 32'h0000028C;
      6'd21: v = 32'h00000146;
      6'd22: v = 32'h000000A3;
      6'd23: v = 32'h00000051;
      6'd24: v = 32'h00000029;
      6'd25: v = 32'h00000014;
      6'd26: v = 32'h0000000A;
      6'd27: v = 32'h00000005;
      6'd28: v = 32'h00000003;
      6'd29: v = 32'h00000001;
      6'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### design/ecef_to_enu_rotation.sv
`default_nettype none
// ECEF-to-ENU vector rotation about a cached reference latitude/longitude.
//
// Config: cfg_we/cfg_index/cfg_data write ref_latitude (index 0) or
// ref_longitude (index 1), binary angles with 2^31 = pi. Each write to either
// index starts a refresh of the sin/cos cache: two passes of one iterative
// CORDIC unit, then four cross terms through one shared multiplier. busy is
// high during the refresh; a write during a refresh restarts it.
// Input: a request is taken on a clock edge with start high and busy low;
// in_x/y/z_component carry the vector. While busy is low, one request per
// cycle is sustained. Output: out_valid pulses for one cycle with
// out_east/north/up, in request order, after the three registered stages
// of the dot-product pipeline (split products, row sums, rounding).
// The receiver cannot stall; results are simply presented.
// Reset (rst_n low, synchronous) clears the pipeline valids, both angles and
// loads the cache with sin = 0, cos = 1.
module ecef_to_enu_rotation (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [ecef_enu_pkg::IN_W-1:0]   in_x_component,
  input  wire logic signed [ecef_enu_pkg::IN_W-1:0]   in_y_component,
  input  wire logic signed [ecef_enu_pkg::IN_W-1:0]   in_z_component,
  output logic                                        out_valid,
  output logic signed [ecef_enu_pkg::OUT_W-1:0]       out_east,
  output logic signed [ecef_enu_pkg::OUT_W-1:0]       out_north,
  output logic signed [ecef_enu_pkg::OUT_W-1:0]       out_up,
  input  wire logic                                   cfg_we,
  input  wire logic [ecef_enu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ecef_enu_pkg::CFG_W-1:0]         cfg_data
);

  ecef_enu_pkg::coef_t coef;
  logic                busy_int;
  logic                req;

  ecef_enu_coef u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy_int),
    .coef      (coef)
  );

  assign req  = start && !busy_int;
  assign busy = busy_int;

  ecef_enu_dot u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (req),
    .in_x      (in_x_component),
    .in_y      (in_y_component),
    .in_z      (in_z_component),
    .coef      (coef),
    .out_vld   (out_valid),
    .out_east  (out_east),
    .out_north (out_north),
    .out_up    (out_up)
  );

endmodule
`default_nettype wire

### design/ecef_enu_cordic.sv
`default_nettype none
module ecef_enu_cordic (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic signed [ecef_enu_pkg::ANG_W-1:0] angle,
  output ecef_enu_pkg::trig_res_t                   res
);

  localparam int CW = ecef_enu_pkg::CORDIC_W;

  logic signed [CW-1:0]             x_r, y_r, z_r;
  logic signed [CW-1:0]             x_nxt, y_nxt, z_nxt;
  logic [ecef_enu_pkg::STEP_W-1:0]  cnt_r;
  logic                             run_r, fin_r, flip_r;

  logic signed [CW-1:0] ang, dx, dy, at, xc, yc;
  logic                 flip;

  // fold angles beyond a quarter turn by half a turn; sin/cos negate later
  always_comb begin
    ang  = CW'(angle);
    flip = (ang > ecef_enu_pkg::CORDIC_ONE) || (ang < -ecef_enu_pkg::CORDIC_ONE);
  end

  always_comb begin
    dx = y_r >>> cnt_r;
    dy = x_r >>> cnt_r;
    at = CW'(ecef_enu_pkg::atan_entry(6'(cnt_r)));
    if (!z_r[CW-1]) begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      fin_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      fin_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ecef_enu_pkg::STEP_W'(ecef_enu_pkg::CORDIC_STEPS - 1)) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= ecef_enu_pkg::CORDIC_GAIN;
      y_r    <= '0;
      flip_r <= flip;
      if (!flip)
        z_r <= ang;
      else if (ang > 0)
        z_r <= ang - ecef_enu_pkg::CORDIC_PI;
      else
        z_r <= ang + ecef_enu_pkg::CORDIC_PI;
    end else if (run_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  always_comb begin
    if (x_r > ecef_enu_pkg::CORDIC_ONE)
      xc = ecef_enu_pkg::CORDIC_ONE;
    else if (x_r < -ecef_enu_pkg::CORDIC_ONE)
      xc = -ecef_enu_pkg::CORDIC_ONE;
    else
      xc = x_r;
    if (y_r > ecef_enu_pkg::CORDIC_ONE)
      yc = ecef_enu_pkg::CORDIC_ONE;
    else if (y_r < -ecef_enu_pkg::CORDIC_ONE)
      yc = -ecef_enu_pkg::CORDIC_ONE;
    else
      yc = y_r;
    res.done = fin_r;
    res.sin  = flip_r ? -yc[ecef_enu_pkg::COEF_W-1:0] : yc[ecef_enu_pkg::COEF_W-1:0];
    res.cos  = flip_r ? -xc[ecef_enu_pkg::COEF_W-1:0] : xc[ecef_enu_pkg::COEF_W-1:0];
  end

endmodule
`default_nettype wire

### design/ecef_enu_coef.sv
`default_nettype none
module ecef_enu_coef (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [ecef_enu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ecef_enu_pkg::CFG_W-1:0]        cfg_data,
  output logic                                       busy,
  output ecef_enu_pkg::coef_t                        coef
);

  localparam int CWD = ecef_enu_pkg::COEF_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_KICK = 5'b00010,
    S_LAT  = 5'b00100,
    S_LON  = 5'b01000,
    S_MUL  = 5'b10000
  } seq_state_t;

  seq_state_t state_r, state_nxt;

  logic signed [ecef_enu_pkg::ANG_W-1:0] lat_r, lon_r;
  logic signed [CWD-1:0]                 sl_r, cl_r, so_r, co_r;
  logic [2:0]                            mcnt_r;
  logic signed [2*CWD-1:0]               prod_r;
  ecef_enu_pkg::coef_t                   coef_r;

  logic                                  cfg_hit;
  logic                                  cs_start;
  logic signed [ecef_enu_pkg::ANG_W-1:0] cs_angle;
  ecef_enu_pkg::trig_res_t               cs_res;
  logic signed [CWD-1:0]                 mul_a, mul_b, prod_q;
  logic signed [2*CWD-1:0]               prod_rnd;

  assign cfg_hit = cfg_we && ((cfg_index == ecef_enu_pkg::REG_LATITUDE) ||
                              (cfg_index == ecef_enu_pkg::REG_LONGITUDE));

  // latitude first, longitude launched as soon as latitude finishes
  assign cs_start = (state_r == S_KICK) || ((state_r == S_LAT) && cs_res.done);
  assign cs_angle = (state_r == S_KICK) ? lat_r : lon_r;

  ecef_enu_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cs_start),
    .angle (cs_angle),
    .res   (cs_res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: state_nxt = S_IDLE;
      S_KICK: state_nxt = S_LAT;
      S_LAT:  if (cs_res.done) state_nxt = S_LON;
      S_LON:  if (cs_res.done) state_nxt = S_MUL;
      S_MUL:  if (mcnt_r == 3'd4) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // a new write restarts the whole refresh
    if (cfg_hit)
      state_nxt = S_KICK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lat_r   <= '0;
      lon_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && (cfg_index == ecef_enu_pkg::REG_LATITUDE))
        lat_r <= cfg_data;
      if (cfg_we && (cfg_index == ecef_enu_pkg::REG_LONGITUDE))
        lon_r <= cfg_data;
    end
  end

  // one shared multiplier for the four cross terms
  always_comb begin
    case (mcnt_r[1:0])
      2'd0: begin mul_a = sl_r; mul_b = co_r; end
      2'd1: begin mul_a = sl_r; mul_b = so_r; end
      2'd2: begin mul_a = cl_r; mul_b = co_r; end
      2'd3: begin mul_a = cl_r; mul_b = so_r; end
      default: begin mul_a = sl_r; mul_b = co_r; end
    endcase
    prod_rnd = prod_r + (2*CWD)'(64'sd536870912);
    prod_q   = prod_rnd[ecef_enu_pkg::FRAC+CWD-1:ecef_enu_pkg::FRAC];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sl_r      <= '0;
      cl_r      <= ecef_enu_pkg::ONE_Q30;
      so_r      <= '0;
      co_r      <= ecef_enu_pkg::ONE_Q30;
      mcnt_r    <= '0;
      // identity swap: east = y, north = z, up = x
      coef_r    <= {{(2*CWD){1'b0}}, ecef_enu_pkg::ONE_Q30,
                    ecef_enu_pkg::ONE_Q30, {(2*CWD){1'b0}},
                    {CWD{1'b0}}, ecef_enu_pkg::ONE_Q30, {CWD{1'b0}}};
    end else begin
      if ((state_r == S_LAT) && cs_res.done) begin
        sl_r <= cs_res.sin;
        cl_r <= cs_res.cos;
      end
      if ((state_r == S_LON) && cs_res.done) begin
        so_r   <= cs_res.sin;
        co_r   <= cs_res.cos;
        mcnt_r <= '0;
      end
      if (state_r == S_MUL) begin
        mcnt_r <= mcnt_r + 3'd1;
        case (mcnt_r)
          3'd1: coef_r.m[1][0] <= -prod_q;
          3'd2: coef_r.m[1][1] <= -prod_q;
          3'd3: coef_r.m[2][0] <= prod_q;
          3'd4: begin
            coef_r.m[2][1] <= prod_q;
            coef_r.m[0][0] <= -so_r;
            coef_r.m[0][1] <= co_r;
            coef_r.m[1][2] <= cl_r;
            coef_r.m[2][2] <= sl_r;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= (2*CWD)'(mul_a) * (2*CWD)'(mul_b);
  end

  assign busy = (state_r != S_IDLE);
  assign coef = coef_r;

endmodule
`default_nettype wire

### design/ecef_enu_dot.sv
`default_nettype none
module ecef_enu_dot (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_vld,
  input  wire logic signed [ecef_enu_pkg::IN_W-1:0]    in_x,
  input  wire logic signed [ecef_enu_pkg::IN_W-1:0]    in_y,
  input  wire logic signed [ecef_enu_pkg::IN_W-1:0]    in_z,
  input  wire ecef_enu_pkg::coef_t                     coef,
  output logic                                         out_vld,
  output logic signed [ecef_enu_pkg::OUT_W-1:0]        out_east,
  output logic signed [ecef_enu_pkg::OUT_W-1:0]        out_north,
  output logic signed [ecef_enu_pkg::OUT_W-1:0]        out_up
);

  localparam int IW    = ecef_enu_pkg::IN_W;
  localparam int SP    = ecef_enu_pkg::SPLIT;
  localparam int HP_W  = ecef_enu_pkg::HP_W;
  localparam int LP_W  = ecef_enu_pkg::LP_W;
  localparam int HS_W  = ecef_enu_pkg::HS_W;
  localparam int LS_W  = ecef_enu_pkg::LS_W;
  localparam int ACC_W = ecef_enu_pkg::ACC_W;
  localparam int FR    = ecef_enu_pkg::FRAC;
  localparam int OW    = ecef_enu_pkg::OUT_W;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FR - 1);

  logic signed [IW-1:0]    vec [3];
  logic signed [IW-SP-1:0] ah  [3];
  logic signed [SP:0]      al  [3];

  logic signed [HP_W-1:0]  ph_r [3][3];
  logic signed [LP_W-1:0]  pl_r [3][3];
  logic signed [HS_W-1:0]  hs_r [3];
  logic signed [LS_W-1:0]  ls_r [3];
  logic signed [ACC_W-1:0] acc  [3];
  logic signed [OW-1:0]    res_r [3];
  logic                    v1_r, v2_r, v3_r;

  assign vec[0] = in_x;
  assign vec[1] = in_y;
  assign vec[2] = in_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ah[k] = vec[k][IW-1:SP];
      al[k] = $signed({1'b0, vec[k][SP-1:0]});
    end
  end

  // stage 1: split partial products
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        ph_r[r][k] <= HP_W'(ah[k]) * HP_W'($signed(coef.m[r][k]));
        pl_r[r][k] <= LP_W'(al[k]) * LP_W'($signed(coef.m[r][k]));
      end
    end
  end

  // stage 2: per-row sums of the high and low halves
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      hs_r[r] <= HS_W'(ph_r[r][0]) + HS_W'(ph_r[r][1]) + HS_W'(ph_r[r][2]);
      ls_r[r] <= LS_W'(pl_r[r][0]) + LS_W'(pl_r[r][1]) + LS_W'(pl_r[r][2]);
    end
  end

  // stage 3: recombine and round half up
  always_comb begin
    for (int r = 0; r < 3; r++)
      acc[r] = (ACC_W'(hs_r[r]) <<< SP) + ACC_W'(ls_r[r]) + HALF;
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++)
      res_r[r] <= acc[r][FR+OW-1:FR];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign out_vld   = v3_r;
  assign out_east  = res_r[0];
  assign out_north = res_r[1];
  assign out_up    = res_r[2];

endmodule
`default_nettype wire

### design/ecef_enu_chk.sv
`default_nettype none
module ecef_enu_chk (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 start,
  input wire logic                                 busy,
  input wire logic                                 out_valid,
  input wire logic                                 cfg_we,
  input wire logic [ecef_enu_pkg::CFG_IDX_W-1:0]   cfg_index
);

  // every request produces a matching result on out_valid
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("request without result after 3 cycles");

  // no result appears without a matching earlier request
  a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n, 3)) |-> $past(start && !busy, 3))
    else $error("result without matching request");

  // a write to a known register starts a cache refresh
  a_cfg_refresh: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == ecef_enu_pkg::REG_LATITUDE ||
                cfg_index == ecef_enu_pkg::REG_LONGITUDE)) |=> busy)
    else $error("register write did not start refresh");

  // a write to an unknown index leaves an idle block idle
  a_cfg_ignore: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && !busy && cfg_index != ecef_enu_pkg::REG_LATITUDE &&
     cfg_index != ecef_enu_pkg::REG_LONGITUDE) |=> !busy)
    else $error("unknown register index started refresh");

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

endmodule

bind ecef_to_enu_rotation ecef_enu_chk u_chk (.*);
`default_nettype wire

### bench/tb_ecef_to_enu_rotation.sv
`timescale 1ns / 100ps

module tb_ecef_to_enu_rotation;

  localparam int IN_W         = ecef_enu_pkg::IN_W;
  localparam int OUT_W        = ecef_enu_pkg::OUT_W;
  localparam int CFG_IDX_W    = ecef_enu_pkg::CFG_IDX_W;
  localparam int CFG_W        = ecef_enu_pkg::CFG_W;
  localparam int FRAC         = ecef_enu_pkg::FRAC;
  localparam int CORDIC_STEPS = ecef_enu_pkg::CORDIC_STEPS;
  localparam logic [CFG_IDX_W-1:0] REG_LATITUDE  = ecef_enu_pkg::REG_LATITUDE;
  localparam logic [CFG_IDX_W-1:0] REG_LONGITUDE = ecef_enu_pkg::REG_LONGITUDE;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int N_PHASES       = 9;
  localparam int PHASE_ITEMS    = 150;
  localparam int DIR_ROWS       = 26;
  localparam int ATAN_N         = 31;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam longint UNIT_Q30  = 64'sd1073741824;
  localparam longint HALF_TURN = 64'sd2147483648;
  localparam longint GAIN_Q30  = 64'sd652032874;
  localparam longint HALF_LSB  = 64'sd536870912;

  localparam logic signed [IN_W-1:0]  V_MIN  = 36'h8_0000_0000;
  localparam logic signed [IN_W-1:0]  V_MAX  = 36'h7_FFFF_FFFF;
  localparam logic signed [IN_W-1:0]  V_ALT0 = 36'h5_5555_5555;
  localparam logic signed [IN_W-1:0]  V_ALT1 = 36'hA_AAAA_AAAA;
  localparam logic signed [OUT_W-1:0] R_MIN  = 38'h38_0000_0000;
  localparam logic signed [OUT_W-1:0] R_MAX  = 38'h07_FFFF_FFFF;
  localparam logic signed [OUT_W-1:0] R_ALT0 = 38'h05_5555_5555;
  localparam logic signed [OUT_W-1:0] R_ALT1 = 38'h3A_AAAA_AAAA;

  typedef struct packed {
    logic signed [OUT_W-1:0] east;
    logic signed [OUT_W-1:0] north;
    logic signed [OUT_W-1:0] up;
  } enu_t;

  typedef enum logic {ROW_VEC, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_W-1:0]        val;
    logic                    typed;
    logic signed [IN_W-1:0]  x;
    logic signed [IN_W-1:0]  y;
    logic signed [IN_W-1:0]  z;
    logic signed [OUT_W-1:0] e;
    logic signed [OUT_W-1:0] n;
    logic signed [OUT_W-1:0] u;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [IN_W-1:0]  in_x_component = '0;
  logic signed [IN_W-1:0]  in_y_component = '0;
  logic signed [IN_W-1:0]  in_z_component = '0;
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_east;
  logic signed [OUT_W-1:0] out_north;
  logic signed [OUT_W-1:0] out_up;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = REG_LATITUDE;
  logic [CFG_W-1:0]        cfg_data = '0;

  ecef_to_enu_rotation i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_x_component (in_x_component),
    .in_y_component (in_y_component),
    .in_z_component (in_z_component),
    .out_valid      (out_valid),
    .out_east       (out_east),
    .out_north      (out_north),
    .out_up         (out_up),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #10 clk = ~clk;

  // atan(2^-i), 2^31 = pi
  longint atan_turn [ATAN_N] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
    32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
    32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9,
    32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051, 32'h0000_0029,
    32'h0000_0014, 32'h0000_000A, 32'h0000_0005, 32'h0000_0003, 32'h0000_0001,
    32'h0000_0001
  };

  dir_row_t dir_tab [DIR_ROWS] = '{
    // reset cache is the identity swap: east = y, north = z, up = x
    '{ROW_VEC, REG_LATITUDE, '0, 1'b1, '0, '0, '0, '0, '0, '0},
    '{ROW_VEC, REG_LATITUDE, '0, 1'b1, V_MAX, V_MIN, V_MAX, R_MIN, R_MAX, R_MAX},
    '{ROW_VEC, REG_LATITUDE, '0, 1'b1, V_MIN, V_MAX, V_MIN, R_MAX, R_MIN, R_MIN},
    '{ROW_VEC, REG_LATITUDE, '0, 1'b1, -36'sd1, 36'sd1, -36'sd1, 38'sd1, -38'sd1, -38'sd1},
    '{ROW_VEC, REG_LATITUDE, '0, 1'b1, V_ALT0, V_ALT1, V_ALT0, R_ALT1, R_ALT0, R_ALT0},
    '{ROW_VEC, REG_LATITUDE, '0, 1'b1, V_ALT1, V_ALT0, V_ALT1, R_ALT0, R_ALT1, R_ALT1},
    // pole, then longitude at -pi (folded by half a turn)
    '{ROW_CFG, REG_LATITUDE, 32'h4000_0000, 1'b0, '0, '0, '0, '0, '0, '0},
    '{ROW_VEC, REG_LATITUDE, '0, 1'b0, V_MAX, V_MAX, V_MAX, '0, '0, '0},
    '{ROW_VEC, REG_LATITUDE, '0, 1'b0, V_MIN, V_MIN, V_MIN, '0, '0, '0},
    '{ROW_CFG, REG_LONGITUDE, 32'h8000_0000, 1'b0, '0, '0, '0, '0, '0, '0},
    '{ROW_VEC, REG_LATITUDE, '0, 1'b0, 36'sd1000, -36'sd2000, 36'sd3000, '0, '0, '0},
    '{ROW_CFG, REG_LATITUDE, 32'hC000_0000, 1'b0, '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_LONGITUDE, 32'h7FFF_FFFF, 1'b0, '0, '0, '0, '0, '0, '0},
    '{ROW_VEC, REG_LATITUDE, '0, 1'b0, V_MAX, V_MIN, V_MAX, '0, '0, '0},
    '{ROW_VEC, REG_LATITUDE, '0, 1'b0, V_MIN, V_MAX, V_MIN, '0, '0, '0},
    // just past a quarter turn on both; latitude outside its nominal range
    '{ROW_CFG, REG_LATITUDE, 32'h4000_0001, 1'b0, '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_LONGITUDE, 32'hBFFF_FFFF, 1'b0, '0, '0, '0, '0, '0, '0},
    '{ROW_VEC, REG_LATITUDE, '0, 1'b0, 36'sd12345, -36'sd67890, 36'sd13579, '0, '0, '0},
    // writes to unmapped indexes leave the cache alone
    '{ROW_CFG, REG_SPARE_2, 32'hFFFF_FFFF, 1'b0, '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_SPARE_3, 32'h1234_5678, 1'b0, '0, '0, '0, '0, '0, '0},
    '{ROW_VEC, REG_LATITUDE, '0, 1'b0, 36'sd12345, -36'sd67890, 36'sd13579, '0, '0, '0},
    '{ROW_CFG, REG_LATITUDE, 32'h2000_0000, 1'b0, '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_LONGITUDE, 32'hE000_0000, 1'b0, '0, '0, '0, '0, '0, '0},
    '{ROW_VEC, REG_LATITUDE, '0, 1'b0, 36'sd1, '0, '0, '0, '0, '0},
    '{ROW_VEC, REG_LATITUDE, '0, 1'b0, '0, 36'sd1, '0, '0, '0, '0},
    '{ROW_VEC, REG_LATITUDE, '0, 1'b0, V_MAX, V_MAX, V_MIN, '0, '0, '0}
  };

  // local copy of the block state
  longint lat_ang, lon_ang;
  longint sin_lat, cos_lat, sin_lon, cos_lon;
  longint rot_m [3][3];

  enu_t        enu_pending [$];
  enu_t        mon_want;
  int unsigned n_mismatch = 0;
  int          stall_cycles = 0;
  int          burst_left = 0;

  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b + HALF_LSB) >>> FRAC;
  endfunction

  function automatic void sincos(input longint ang, output longint sn, output longint cs);
    longint x, y, z, dx, dy, a;
    logic   flip;
    int     k;
    x = GAIN_Q30;
    y = 0;
    flip = 1'b0;
    // fold angles past a quarter turn by half a turn, negate afterwards
    if (ang > UNIT_Q30 || ang < -UNIT_Q30) begin
      flip = 1'b1;
      ang = (ang > 0) ? ang - HALF_TURN : ang + HALF_TURN;
    end
    z = ang;
    for (k = 0; k < CORDIC_STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      a = (k < ATAN_N) ? atan_turn[k] : 64'sd0;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= a;
      end else begin
        x += dx;
        y -= dy;
        z += a;
      end
    end
    x = (x > UNIT_Q30) ? UNIT_Q30 : ((x < -UNIT_Q30) ? -UNIT_Q30 : x);
    y = (y > UNIT_Q30) ? UNIT_Q30 : ((y < -UNIT_Q30) ? -UNIT_Q30 : y);
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  // rows east, north, up; columns x, y, z
  function automatic void build_matrix();
    rot_m[0][0] = -sin_lon;
    rot_m[0][1] = cos_lon;
    rot_m[0][2] = 0;
    rot_m[1][0] = -q30_mul(sin_lat, cos_lon);
    rot_m[1][1] = -q30_mul(sin_lat, sin_lon);
    rot_m[1][2] = cos_lat;
    rot_m[2][0] = q30_mul(cos_lat, cos_lon);
    rot_m[2][1] = q30_mul(cos_lat, sin_lon);
    rot_m[2][2] = sin_lat;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
    logic signed [CFG_W-1:0] sval;
    sval = val;
    if (idx == REG_LATITUDE)
      lat_ang = sval;
    else if (idx == REG_LONGITUDE)
      lon_ang = sval;
    else
      return;
    sincos(lat_ang, sin_lat, cos_lat);
    sincos(lon_ang, sin_lon, cos_lon);
    build_matrix();
  endfunction

  // exact dot product, then round half up to an integer
  function automatic enu_t rotate_vec(input logic signed [IN_W-1:0] x, y, z);
    logic signed [71:0]      v [3];
    logic signed [71:0]      acc;
    logic signed [OUT_W-1:0] row_out [3];
    int                      r, c;
    v[0] = 72'(x);
    v[1] = 72'(y);
    v[2] = 72'(z);
    for (r = 0; r < 3; r++) begin
      acc = 72'(HALF_LSB);
      for (c = 0; c < 3; c++)
        acc += v[c] * 72'(rot_m[r][c]);
      acc = acc >>> FRAC;
      row_out[r] = acc[OUT_W-1:0];
    end
    return {row_out[0], row_out[1], row_out[2]};
  endfunction

  function automatic logic signed [IN_W-1:0] rand_comp();
    logic [63:0] raw;
    int          sm;
    raw = {$urandom, $urandom};
    sm = int'($urandom_range(0, 2000)) - 1000;
    case ($urandom_range(0, 9))
      0: return V_MIN;
      1: return V_MAX;
      2: return IN_W'(sm);
      3: return $signed(raw[23:0]);
      default: return raw[IN_W-1:0];
    endcase
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_vec(input logic signed [IN_W-1:0] x, y, z,
                          input logic typed, input enu_t typed_res);
    start <= 1'b1;
    in_x_component <= x;
    in_y_component <= y;
    in_z_component <= z;
    do @(posedge clk); while (busy);
    if (typed)
      enu_pending.push_back(typed_res);
    else
      enu_pending.push_back(rotate_vec(x, y, z));
    @(negedge clk);
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(0, 12);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (enu_pending.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    apply_reg(idx, val);
  endtask

  task automatic cfg_done();
    cfg_we <= 1'b0;
    repeat (2) @(negedge clk);
  endtask

  task automatic check_field(input string tag, input logic signed [OUT_W-1:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, tag, want, got);
      n_mismatch++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (enu_pending.size() == 0) begin
        $display("%0t: result with no request pending: east %0d north %0d up %0d",
                 $time, out_east, out_north, out_up);
        n_mismatch++;
      end else begin
        mon_want = enu_pending.pop_front();
        check_field("east", mon_want.east, out_east);
        check_field("north", mon_want.north, out_north);
        check_field("up", mon_want.up, out_up);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[ecef_to_enu_rotation] ERROR");
      $finish;
    end
  end

  initial begin
    int               r, ph, k, hold_at;
    logic             cfg_open;
    logic [CFG_W-1:0] lat_val, lon_val;

    lat_ang = 0;
    lon_ang = 0;
    sin_lat = 0;
    cos_lat = UNIT_Q30;
    sin_lon = 0;
    cos_lon = UNIT_Q30;
    build_matrix();

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    cfg_open = 1'b0;
    for (r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].kind == ROW_CFG) begin
        if (!cfg_open)
          drain();
        cfg_open = 1'b1;
        cfg_write(dir_tab[r].idx, dir_tab[r].val);
      end else begin
        if (cfg_open)
          cfg_done();
        cfg_open = 1'b0;
        send_vec(dir_tab[r].x, dir_tab[r].y, dir_tab[r].z, dir_tab[r].typed,
                 {dir_tab[r].e, dir_tab[r].n, dir_tab[r].u});
        pace();
      end
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          lat_val = 32'h4000_0000;
          lon_val = 32'h8000_0000;
        end
        1: begin
          lat_val = 32'hC000_0000;
          lon_val = 32'h7FFF_FFFF;
        end
        2: begin
          lat_val = 32'h8000_0000;
          lon_val = 32'h0000_0000;
        end
        3: begin
          lat_val = 32'h0000_0000;
          lon_val = 32'h4000_0000;
        end
        default: begin
          lat_val = ($urandom_range(0, 3) == 0) ? $urandom
                    : $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
          lon_val = $urandom;
        end
      endcase
      if (ph % 3 == 1)
        cfg_write(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3, $urandom);
      if (ph >= 5 && $urandom_range(0, 2) == 0) begin
        // update one angle only
        if ($urandom_range(0, 1) == 0)
          cfg_write(REG_LATITUDE, lat_val);
        else
          cfg_write(REG_LONGITUDE, lon_val);
      end else if ($urandom_range(0, 1) == 0) begin
        cfg_write(REG_LATITUDE, lat_val);
        cfg_write(REG_LONGITUDE, lon_val);
      end else begin
        cfg_write(REG_LONGITUDE, lon_val);
        cfg_write(REG_LATITUDE, lat_val);
      end
      cfg_done();

      // sometimes hold requests mid-phase until the pipe is empty
      hold_at = (ph == 4 || $urandom_range(0, 1) == 0) ? $urandom_range(10, PHASE_ITEMS - 10)
                                                      : -1;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k == hold_at)
          drain();
        send_vec(rand_comp(), rand_comp(), rand_comp(), 1'b0, '0);
        pace();
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (n_mismatch == 0)
      $display("[ecef_to_enu_rotation] OK");
    else
      $display("[ecef_to_enu_rotation] ERROR");
    $finish;
  end

endmodule
